// File: src/rycc_pkg.sv
// Shared types, fixed-point weights and clip settings for the BT.709 converter.
// Depends on nothing; rycc_row_lane and the top level import it.
package rycc_pkg;

   localparam int COEF_FRAC_BITS = 20;

   // Operand: a component (0..65535) or a centred chroma (-65535..65535).
   localparam int OP_W   = 17;
   // A weight magnitude stays below 2^(F+2); the luma pass-through weight is 2^(F+1).
   localparam int COEF_W = COEF_FRAC_BITS + 3;
   localparam int PROD_W = OP_W + COEF_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int COMP_W = 16;

   typedef logic signed [OP_W-1:0]   op_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic [COMP_W-1:0]        comp_type;

   typedef enum logic {
      DIR_TO_YCBCR = 1'b0,
      DIR_TO_RGB   = 1'b1
   } dir_type;

   typedef logic [0:0] csr_index_type;
   typedef logic [0:0] csr_data_type;
   localparam csr_index_type CSR_DIRECTION = 1'b0;
   localparam csr_index_type CSR_WIDE      = 1'b1;

   localparam int COMP_MAX_NARROW = 255;
   localparam int COMP_MAX_WIDE   = 65535;

   // Rounded weights, round-half-up of num * 2^F / den.
   localparam longint ONE_L  = longint'(1) << COEF_FRAC_BITS;
   localparam longint HALF_L = ONE_L >> 1;
   localparam longint TWO_L  = ONE_L << 1;
   localparam longint W_R    = ((longint'(2126) << COEF_FRAC_BITS) + 5000) / 10000;
   localparam longint W_B    = ((longint'(722) << COEF_FRAC_BITS) + 5000) / 10000;
   localparam longint W_G    = ONE_L - W_R - W_B;
   localparam longint W_UR   = ((longint'(2126) << COEF_FRAC_BITS) + 9278) / 18556;
   localparam longint W_VB   = ((longint'(722) << COEF_FRAC_BITS) + 7874) / 15748;
   localparam longint W_IR   = ((longint'(15748) << COEF_FRAC_BITS) + 5000) / 10000;
   localparam longint W_IB   = ((longint'(18556) << COEF_FRAC_BITS) + 5000) / 10000;
   localparam longint W_IGCR =
      ((longint'(33480248) << COEF_FRAC_BITS) + 35760000) / 71520000;
   localparam longint W_IGCB =
      ((longint'(13397432) << COEF_FRAC_BITS) + 35760000) / 71520000;

   // Rows are outputs, columns are operands (comp0, comp1, comp2).
   localparam coef_type FWD_COEF [3][3] = '{
      '{coef_type'(W_R), coef_type'(W_G), coef_type'(W_B)},
      '{coef_type'(-W_UR), coef_type'(W_UR - HALF_L), coef_type'(HALF_L)},
      '{coef_type'(HALF_L), coef_type'(W_VB - HALF_L), coef_type'(-W_VB)}
   };

   // Operands here are luma, centred Cb and centred Cr; only the chroma carry one fractional bit.
   localparam coef_type INV_COEF [3][3] = '{
      '{coef_type'(TWO_L), coef_type'(0), coef_type'(W_IR)},
      '{coef_type'(TWO_L), coef_type'(-W_IGCB), coef_type'(-W_IGCR)},
      '{coef_type'(TWO_L), coef_type'(W_IB), coef_type'(0)}
   };

   typedef struct packed {
      sum_type lo;
      sum_type hi;
      sum_type off;
      logic    extra_shift;
   } clip_type;

   typedef struct packed {
      logic ld_b;
      logic ld_c;
      logic ld_d;
   } lane_en_type;

   function automatic clip_type clip_sel(input dir_type dir, input logic wide,
                                         input logic luma);
      clip_type c;
      sum_type  m;
      m = wide ? sum_type'(COMP_MAX_WIDE) : sum_type'(COMP_MAX_NARROW);
      c.lo = '0;
      c.off = '0;
      c.extra_shift = 1'b0;
      c.hi = m <<< COEF_FRAC_BITS;
      if (dir == DIR_TO_RGB) begin
         c.hi = m <<< (COEF_FRAC_BITS + 1);
         c.extra_shift = 1'b1;
      end else if (!luma) begin
         // Chroma is clipped symmetrically and then moved up by half scale.
         c.hi = m <<< (COEF_FRAC_BITS - 1);
         c.lo = -c.hi;
         c.off = c.hi;
      end
      return c;
   endfunction

endpackage

// File: src/rycc_channels.sv
// Valid/ready channel interfaces for pixel items in and converted items out.
// Standalone; the field widths match the package's 16-bit component type.
interface rycc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] comp0;
   logic [15:0] comp1;
   logic [15:0] comp2;
   logic [15:0] alpha_in;

   modport source(output valid, output comp0, output comp1, output comp2,
                  output alpha_in, input ready);
   modport sink(input valid, input comp0, input comp1, input comp2,
                input alpha_in, output ready);
endinterface

interface rycc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out0;
   logic [15:0] out1;
   logic [15:0] out2;
   logic [15:0] alpha_out;

   modport source(output valid, output out0, output out1, output out2,
                  output alpha_out, input ready);
   modport sink(input valid, input out0, input out1, input out2,
                input alpha_out, output ready);
endinterface

// File: src/rycc_row_lane.sv
// One output row of the converter: three products, their sum, then clip and scale.
// Uses rycc_pkg; load enables come from the pipeline control in the top level.
module rycc_row_lane (
   input  logic                  clock,
   input  rycc_pkg::lane_en_type en,
   input  rycc_pkg::op_type      x [3],
   input  rycc_pkg::coef_type    coef [3],
   input  rycc_pkg::clip_type    clip,
   output rycc_pkg::comp_type    result
);
   import rycc_pkg::*;

   prod_type prod_in [3];
   prod_type prod_ff [3];
   clip_type clip_b_ff;
   sum_type  sum_in;
   sum_type  sum_ff;
   clip_type clip_c_ff;
   sum_type  clipped;
   sum_type  shifted_src;
   comp_type result_in;
   comp_type result_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         prod_in[j] = prod_type'(x[j]) * prod_type'(coef[j]);
      end
   end

   assign sum_in = sum_type'(prod_ff[0]) + sum_type'(prod_ff[1]) + sum_type'(prod_ff[2]);

   always_comb begin
      if (sum_ff < clip_c_ff.lo) begin
         clipped = clip_c_ff.lo;
      end else if (sum_ff > clip_c_ff.hi) begin
         clipped = clip_c_ff.hi;
      end else begin
         clipped = sum_ff;
      end
      shifted_src = clipped + clip_c_ff.off;
      // The value is non-negative here, so a part-select is the truncating shift.
      if (clip_c_ff.extra_shift) begin
         result_in = shifted_src[COEF_FRAC_BITS+COMP_W:COEF_FRAC_BITS+1];
      end else begin
         result_in = shifted_src[COEF_FRAC_BITS+COMP_W-1:COEF_FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en.ld_b) begin
         prod_ff <= prod_in;
         clip_b_ff <= clip;
      end
      if (en.ld_c) begin
         sum_ff <= sum_in;
         clip_c_ff <= clip_b_ff;
      end
      if (en.ld_d) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: src/rgb_ycbcr_bt709_convert_unit.sv
// Top level of the BT.709 full-range RGB/YCbCr converter: control and three row lanes.
// Depends on rycc_pkg, rycc_channels.sv and rycc_row_lane.
//
//   channel   direction   carries
//   req_px    in          comp0, comp1, comp2, alpha_in   (valid/ready)
//   rsp_px    out         out0, out1, out2, alpha_out     (valid/ready)
//   csr_*     in          write enable, register index, write data
//
// One item per cycle while the output is not stalled; each item passes four register stages
// (operand capture, multiply, three-term sum, clip and scale) and is offered at the output
// from the clip and scale register.
// The multiply stage, one multiplier per weight, sets the cycle time.
// Reset clears the stage valid bits and both configuration registers.
// An output stall holds the full stages behind it up to the first empty one, in the same
// cycle; an empty stage still takes an item, so the input stalls only with all four full.
module rgb_ycbcr_bt709_convert_unit (
   input  logic                    clock,
   input  logic                    reset,
   rycc_req_if.sink                req_px,
   rycc_rsp_if.source              rsp_px,
   input  logic                    csr_wr_en,
   input  rycc_pkg::csr_index_type csr_index,
   input  rycc_pkg::csr_data_type  csr_wdata
);
   import rycc_pkg::*;

   dir_type     dir_ff;
   logic        wide_ff;

   logic        vld_a_ff, vld_b_ff, vld_c_ff, vld_d_ff;
   logic        ready_a, ready_b, ready_c, ready_d;
   lane_en_type lane_en;

   op_type      x_in [3];
   op_type      x_a_ff [3];
   dir_type     dir_a_ff;
   logic        wide_a_ff, wide_b_ff, wide_c_ff, wide_d_ff;
   comp_type    alpha_a_ff, alpha_b_ff, alpha_c_ff, alpha_d_ff;
   comp_type    res [3];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= DIR_TO_YCBCR;
         wide_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DIRECTION: dir_ff <= dir_type'(csr_wdata);
            CSR_WIDE:      wide_ff <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // A stage takes a new item when it is empty or its item moves on.
   assign ready_d = !vld_d_ff || rsp_px.ready;
   assign ready_c = !vld_c_ff || ready_d;
   assign ready_b = !vld_b_ff || ready_c;
   assign ready_a = !vld_a_ff || ready_b;
   assign req_px.ready = ready_a;

   assign lane_en.ld_b = ready_b;
   assign lane_en.ld_c = ready_c;
   assign lane_en.ld_d = ready_d;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
         vld_d_ff <= 1'b0;
      end else begin
         if (ready_a) vld_a_ff <= req_px.valid;
         if (ready_b) vld_b_ff <= vld_a_ff;
         if (ready_c) vld_c_ff <= vld_b_ff;
         if (ready_d) vld_d_ff <= vld_c_ff;
      end
   end

   // Operand capture: mask to the component width, and centre chroma for the inverse.
   always_comb begin
      comp_type c0, c1, c2;
      op_type   m;
      c0 = wide_ff ? req_px.comp0 : {8'h00, req_px.comp0[7:0]};
      c1 = wide_ff ? req_px.comp1 : {8'h00, req_px.comp1[7:0]};
      c2 = wide_ff ? req_px.comp2 : {8'h00, req_px.comp2[7:0]};
      m = wide_ff ? op_type'(COMP_MAX_WIDE) : op_type'(COMP_MAX_NARROW);
      x_in[0] = op_type'({1'b0, c0});
      if (dir_ff == DIR_TO_RGB) begin
         // 2*C can exceed the signed range, but the difference always fits.
         x_in[1] = op_type'({c1, 1'b0}) - m;
         x_in[2] = op_type'({c2, 1'b0}) - m;
      end else begin
         x_in[1] = op_type'({1'b0, c1});
         x_in[2] = op_type'({1'b0, c2});
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a) begin
         x_a_ff <= x_in;
         dir_a_ff <= dir_ff;
         wide_a_ff <= wide_ff;
         alpha_a_ff <= req_px.alpha_in;
      end
      if (ready_b) begin
         wide_b_ff <= wide_a_ff;
         alpha_b_ff <= alpha_a_ff;
      end
      if (ready_c) begin
         wide_c_ff <= wide_b_ff;
         alpha_c_ff <= alpha_b_ff;
      end
      if (ready_d) begin
         wide_d_ff <= wide_c_ff;
         alpha_d_ff <= alpha_c_ff;
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      coef_type row_coef [3];
      clip_type row_clip;

      always_comb begin
         for (int j = 0; j < 3; j++) begin
            row_coef[j] = (dir_a_ff == DIR_TO_RGB) ? INV_COEF[r][j] : FWD_COEF[r][j];
         end
         row_clip = clip_sel(dir_a_ff, wide_a_ff, (r == 0));
      end

      rycc_row_lane u_lane (
         .clock  (clock),
         .en     (lane_en),
         .x      (x_a_ff),
         .coef   (row_coef),
         .clip   (row_clip),
         .result (res[r])
      );
   end

   assign rsp_px.valid = vld_d_ff;
   assign rsp_px.out0 = res[0];
   assign rsp_px.out1 = res[1];
   assign rsp_px.out2 = res[2];
   assign rsp_px.alpha_out = alpha_d_ff;

   a_accept_fills_a: assert property (@(posedge clock) disable iff (reset)
      (req_px.valid && req_px.ready) |=> vld_a_ff)
      else $error("accepted item did not reach the capture stage");

   a_no_loss_c_to_d: assert property (@(posedge clock) disable iff (reset)
      (vld_c_ff && ready_c) |=> vld_d_ff)
      else $error("item lost between sum and output stages");

   a_alpha_follows: assert property (@(posedge clock) disable iff (reset)
      (vld_c_ff && ready_c) |=> (rsp_px.alpha_out == $past(alpha_c_ff)))
      else $error("alpha did not follow its item to the output");

   a_narrow_range: assert property (@(posedge clock) disable iff (reset)
      (vld_d_ff && !wide_d_ff) |->
         (rsp_px.out0[15:8] == 8'h00 && rsp_px.out1[15:8] == 8'h00 &&
          rsp_px.out2[15:8] == 8'h00))
      else $error("8-bit result out of range");

endmodule
